// ===== design/a4s_pkg.sv =====
// ============================================================================
// a4s_pkg
// Shared types and codes for the 64-bit ARM subset step core.
// ============================================================================
package a4s_pkg;

    localparam int GeneralRegCount = 31;
    localparam int RegIdxW         = 5;

    localparam logic [RegIdxW-1:0] REG_ZR = 5'd31;
    localparam logic [RegIdxW-1:0] REG_LR = 5'd30;

    // item kinds
    localparam logic [1:0] KIND_INSTR   = 2'd0;
    localparam logic [1:0] KIND_RESP    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_HALTED = 3'd1;
    localparam logic [2:0] ST_FAULT  = 3'd2;
    localparam logic [2:0] ST_UNIMPL = 3'd3;
    localparam logic [2:0] ST_WAIT   = 3'd4;
    localparam logic [2:0] ST_ORDER  = 3'd5;

    // data access codes
    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_READ  = 2'd1;
    localparam logic [1:0] ACC_WRITE = 2'd2;

    // encodings
    localparam logic [31:0] ENC_NOP      = 32'hD503201F;
    localparam logic [31:0] MASK_HLT     = 32'hFFE0001F;
    localparam logic [31:0] ENC_HLT      = 32'hD4400000;
    localparam logic [31:0] MASK_BR      = 32'hFC000000;
    localparam logic [31:0] ENC_B        = 32'h14000000;
    localparam logic [31:0] ENC_BL       = 32'h94000000;
    localparam logic [31:0] MASK_RET     = 32'hFFFFFC1F;
    localparam logic [31:0] ENC_RET      = 32'hD65F0000;
    localparam logic [31:0] MASK_MOV     = 32'h7F800000;
    localparam logic [31:0] ENC_MOVZ     = 32'h52800000;
    localparam logic [31:0] ENC_MOVK     = 32'h72800000;
    localparam logic [31:0] ENC_ADDI     = 32'h11000000;
    localparam logic [31:0] ENC_SUBI     = 32'h51000000;
    localparam logic [31:0] MASK_LDST    = 32'hFFC00000;
    localparam logic [31:0] ENC_STR_X    = 32'hF9000000;
    localparam logic [31:0] ENC_LDR_X    = 32'hF9400000;
    localparam logic [31:0] ENC_STR_W    = 32'hB9000000;
    localparam logic [31:0] ENC_LDR_W    = 32'hB9400000;

    typedef struct packed {
        logic [63:0]        pc;
        logic [63:0]        sp;
        logic               halted;
        logic [63:0]        retired;
        logic [1:0]         pend_acc;
        logic [RegIdxW-1:0] pend_dest;
        logic               pend_wide;
        logic [31:0]        pend_word;
    } a4s_state_t;

    typedef struct packed {
        logic               en;
        logic [RegIdxW-1:0] addr;
        logic [63:0]        data;
    } a4s_wr_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] fetch_pc;
        logic [1:0]  access;
        logic [63:0] access_address;
        logic [3:0]  access_bytes;
        logic [63:0] write_data;
        logic [31:0] instruction;
        logic [63:0] retired;
    } a4s_result_t;

endpackage

// ===== design/a4s_if.sv =====
// ============================================================================
// a4s_in_if / a4s_out_if
// Valid/ready channels for input items and result items.
// ============================================================================
interface a4s_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] data;
    logic        bus_ok;

    modport source (output valid, output kind, output data, output bus_ok, input ready);
    modport sink   (input valid, input kind, input data, input bus_ok, output ready);
endinterface

interface a4s_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] fetch_pc;
    logic [1:0]  access;
    logic [63:0] access_address;
    logic [3:0]  access_bytes;
    logic [63:0] write_data;
    logic [31:0] instruction;
    logic [63:0] retired;

    modport source (output valid, output status, output fetch_pc, output access,
                    output access_address, output access_bytes, output write_data,
                    output instruction, output retired, input ready);
    modport sink   (input valid, input status, input fetch_pc, input access,
                    input access_address, input access_bytes, input write_data,
                    input instruction, input retired, output ready);
endinterface

// ===== design/a4s_regfile.sv =====
// ============================================================================
// a4s_regfile
// General register memory: two synchronous read ports, one write port,
// per-entry valid bits cleared on restart, forwarding of a same-edge write.
// ============================================================================
module a4s_regfile
    import a4s_pkg::*;
#(
    parameter int REG_COUNT = GeneralRegCount
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [RegIdxW-1:0] rd_addr_a,
    input  logic [RegIdxW-1:0] rd_addr_b,
    input  a4s_wr_t            wr,
    input  logic               clear,
    output logic [63:0]        rd_data_a,
    output logic [63:0]        rd_data_b
);

    logic [63:0]          mem [0:REG_COUNT-1];
    logic [63:0]          rdata_a_reg;
    logic [63:0]          rdata_b_reg;
    logic [RegIdxW-1:0]   addr_a_reg;
    logic [RegIdxW-1:0]   addr_b_reg;
    logic                 fwd_a_reg;
    logic                 fwd_b_reg;
    logic [63:0]          fwd_data_reg;
    logic [REG_COUNT-1:0] valid_reg;

    // write and read the array
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rdata_a_reg  <= mem[rd_addr_a];
            rdata_b_reg  <= mem[rd_addr_b];
            addr_a_reg   <= rd_addr_a;
            addr_b_reg   <= rd_addr_b;
            fwd_data_reg <= wr.data;
        end
    end

    // capture forwarding hits and track written entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_a_reg <= 1'b0;
            fwd_b_reg <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                fwd_a_reg <= wr.en && (wr.addr == rd_addr_a);
                fwd_b_reg <= wr.en && (wr.addr == rd_addr_b);
            end
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
        end
    end

    // pick forwarded, stored or cleared value
    always_comb
    begin
        if (fwd_a_reg)
            rd_data_a = fwd_data_reg;
        else if (addr_a_reg < RegIdxW'(REG_COUNT) && valid_reg[addr_a_reg])
            rd_data_a = rdata_a_reg;
        else
            rd_data_a = '0;
        if (fwd_b_reg)
            rd_data_b = fwd_data_reg;
        else if (addr_b_reg < RegIdxW'(REG_COUNT) && valid_reg[addr_b_reg])
            rd_data_b = rdata_b_reg;
        else
            rd_data_b = '0;
    end

endmodule

// ===== design/a4s_exec.sv =====
// ============================================================================
// a4s_exec
// Decode and execute one item against the architectural state.
// ============================================================================
module a4s_exec
    import a4s_pkg::*;
(
    input  logic [1:0]  kind,
    input  logic [63:0] data,
    input  logic        bus_ok,
    input  logic [63:0] reg_a,
    input  logic [63:0] reg_b,
    input  a4s_state_t  st,
    input  logic [63:0] reset_pc,
    output a4s_state_t  st_next,
    output a4s_wr_t     wr,
    output logic        clear,
    output a4s_result_t res
);

    logic [31:0]        w;
    logic [RegIdxW-1:0] rn;
    logic [RegIdxW-1:0] rd;
    logic [63:0]        pc4;
    logic [63:0]        base_sp;
    logic [63:0]        rn_val;
    logic [63:0]        rd_val;
    logic [63:0]        br_off;
    logic [5:0]         mv_sh;
    logic [63:0]        mv_imm;
    logic [63:0]        mv_val;
    logic [63:0]        as_imm;
    logic [63:0]        as_val;
    logic [63:0]        ls_off;
    logic               is_ldst;
    logic [2:0]         status;
    logic [31:0]        word;

    assign w       = data[31:0];
    assign rn      = w[9:5];
    assign rd      = w[4:0];
    assign pc4     = st.pc + 64'd4;
    assign base_sp = (rn == REG_ZR) ? st.sp : reg_a;
    assign rn_val  = (rn == REG_ZR) ? 64'd0 : reg_a;
    assign rd_val  = (rd == REG_ZR) ? 64'd0 : reg_b;
    assign br_off  = {{36{w[25]}}, w[25:0], 2'b00};

    // wide move: place the 16-bit field, keep the rest for MOVK
    assign mv_sh  = {w[22:21], 4'b0000};
    assign mv_imm = {48'd0, w[20:5]} << mv_sh;
    always_comb
    begin
        mv_val = ((w & MASK_MOV) == ENC_MOVK)
               ? ((rd_val & ~(64'h0000_0000_0000_FFFF << mv_sh)) | mv_imm)
               : mv_imm;
        if (!w[31])
            mv_val[63:32] = '0;
    end

    // add/sub immediate
    assign as_imm = w[22] ? {40'd0, w[21:10], 12'd0} : {52'd0, w[21:10]};
    always_comb
    begin
        as_val = ((w & MASK_MOV) == ENC_SUBI) ? (base_sp - as_imm) : (base_sp + as_imm);
        if (!w[31])
            as_val[63:32] = '0;
    end

    // load/store scaled offset
    assign ls_off  = w[30] ? {49'd0, w[21:10], 3'd0} : {50'd0, w[21:10], 2'd0};
    assign is_ldst = ((w & MASK_LDST) == ENC_STR_X) || ((w & MASK_LDST) == ENC_LDR_X) ||
                     ((w & MASK_LDST) == ENC_STR_W) || ((w & MASK_LDST) == ENC_LDR_W);

    always_comb
    begin
        st_next = st;
        wr      = '0;
        clear   = 1'b0;
        res     = '0;
        status  = ST_ORDER;
        word    = '0;
        unique case (kind)
            KIND_RESTART:
            begin
                st_next    = '0;
                st_next.pc = reset_pc;
                clear      = 1'b1;
                status     = ST_OK;
            end
            KIND_INSTR:
            begin
                if (st.halted)
                    status = ST_HALTED;
                else if (st.pend_acc != ACC_NONE)
                    status = ST_ORDER;
                else if (!bus_ok)
                    status = ST_FAULT;
                else
                begin
                    word   = w;
                    status = ST_OK;
                    priority if (w == ENC_NOP)
                    begin
                        st_next.pc      = pc4;
                        st_next.retired = st.retired + 64'd1;
                    end
                    else if ((w & MASK_HLT) == ENC_HLT)
                    begin
                        st_next.halted  = 1'b1;
                        st_next.retired = st.retired + 64'd1;
                        status          = ST_HALTED;
                    end
                    else if ((w & MASK_BR) == ENC_B || (w & MASK_BR) == ENC_BL)
                    begin
                        if ((w & MASK_BR) == ENC_BL)
                        begin
                            wr.en   = 1'b1;
                            wr.addr = REG_LR;
                            wr.data = pc4;
                        end
                        st_next.pc      = st.pc + br_off;
                        st_next.retired = st.retired + 64'd1;
                    end
                    else if ((w & MASK_RET) == ENC_RET)
                    begin
                        st_next.pc      = rn_val;
                        st_next.retired = st.retired + 64'd1;
                    end
                    else if ((w & MASK_MOV) == ENC_MOVZ || (w & MASK_MOV) == ENC_MOVK)
                    begin
                        if (!w[31] && w[22])
                            status = ST_UNIMPL;
                        else
                        begin
                            wr.en           = (rd != REG_ZR);
                            wr.addr         = rd;
                            wr.data         = mv_val;
                            st_next.pc      = pc4;
                            st_next.retired = st.retired + 64'd1;
                        end
                    end
                    else if ((w & MASK_MOV) == ENC_ADDI || (w & MASK_MOV) == ENC_SUBI)
                    begin
                        if (rd == REG_ZR)
                            st_next.sp = as_val;
                        wr.en           = (rd != REG_ZR);
                        wr.addr         = rd;
                        wr.data         = as_val;
                        st_next.pc      = pc4;
                        st_next.retired = st.retired + 64'd1;
                    end
                    else if (is_ldst)
                    begin
                        st_next.pend_acc  = w[22] ? ACC_READ : ACC_WRITE;
                        st_next.pend_dest = rd;
                        st_next.pend_wide = w[30];
                        st_next.pend_word = w;
                        res.access         = st_next.pend_acc;
                        res.access_address = base_sp + ls_off;
                        res.access_bytes   = w[30] ? 4'd8 : 4'd4;
                        if (!w[22])
                            res.write_data = w[30] ? rd_val : {32'd0, rd_val[31:0]};
                        status = ST_WAIT;
                    end
                    else
                        status = ST_UNIMPL;
                end
            end
            KIND_RESP:
            begin
                if (st.pend_acc != ACC_NONE)
                begin
                    word = st.pend_word;
                    if (!bus_ok)
                        status = ST_FAULT;
                    else
                    begin
                        if (st.pend_acc == ACC_READ)
                        begin
                            wr.en   = (st.pend_dest != REG_ZR);
                            wr.addr = st.pend_dest;
                            wr.data = st.pend_wide ? data : {32'd0, data[31:0]};
                        end
                        st_next.pc      = pc4;
                        st_next.retired = st.retired + 64'd1;
                        status          = ST_OK;
                    end
                    st_next.pend_acc  = ACC_NONE;
                    st_next.pend_dest = '0;
                    st_next.pend_wide = 1'b0;
                    st_next.pend_word = '0;
                end
            end
            default:
                status = ST_ORDER;
        endcase
        res.status      = status;
        res.fetch_pc    = st_next.pc;
        res.instruction = word;
        res.retired     = st_next.retired;
    end

endmodule

// ===== design/arm64_subset_instruction_step_core.sv =====
// ============================================================================
// arm64_subset_instruction_step_core
// Steps a small 64-bit ARM integer subset, one result per input item.
// ============================================================================
//  channel   dir  transfer when        payload
//  in_ch     in   valid && ready       kind, data, bus_ok
//  out_ch    out  valid && ready       status, fetch_pc, access, ..., retired
//  cfg       in   cfg_wr_en            cfg_wr_data -> reset_pc
//
//  The register memory is read at the input transfer and the execute stage
//  writes it back when its result enters the result register; one item per
//  cycle is accepted while results drain.
//  Reset clears control state; restart items clear registers via valid bits.
//  A stalled result register holds the execute stage and input ready.
// ============================================================================
module arm64_subset_instruction_step_core
    import a4s_pkg::*;
#(
    parameter int GENERAL_REG_COUNT = GeneralRegCount
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    a4s_in_if.sink      in_ch,
    a4s_out_if.source   out_ch
);

    logic        ex_vld_reg;
    logic [1:0]  ex_kind_reg;
    logic [63:0] ex_data_reg;
    logic        ex_ok_reg;
    logic        out_vld_reg;
    a4s_result_t out_res_reg;
    a4s_state_t  st_reg;
    logic [63:0] reset_pc_reg;

    logic        ex_advance;
    logic        in_take;
    logic [63:0] reg_a;
    logic [63:0] reg_b;
    a4s_state_t  st_next;
    a4s_wr_t     wr;
    logic        clear;
    a4s_result_t res;

    assign ex_advance  = ex_vld_reg && (!out_vld_reg || out_ch.ready);
    assign in_ch.ready = !ex_vld_reg || ex_advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    a4s_regfile #(
        .REG_COUNT (GENERAL_REG_COUNT)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_take),
        .rd_addr_a (in_ch.data[9:5]),
        .rd_addr_b (in_ch.data[4:0]),
        .wr        (ex_advance ? wr : '0),
        .clear     (ex_advance && clear),
        .rd_data_a (reg_a),
        .rd_data_b (reg_b)
    );

    a4s_exec u_exec (
        .kind     (ex_kind_reg),
        .data     (ex_data_reg),
        .bus_ok   (ex_ok_reg),
        .reg_a    (reg_a),
        .reg_b    (reg_b),
        .st       (st_reg),
        .reset_pc (reset_pc_reg),
        .st_next  (st_next),
        .wr       (wr),
        .clear    (clear),
        .res      (res)
    );

    // hold the item payload for the execute stage and register its result
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ex_kind_reg <= in_ch.kind;
            ex_data_reg <= in_ch.data;
            ex_ok_reg   <= in_ch.bus_ok;
        end
        if (ex_advance)
        begin
            out_res_reg <= res;
        end
    end

    // advance control, state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            st_reg       <= '0;
            reset_pc_reg <= '0;
        end
        else
        begin
            if (in_take)
                ex_vld_reg <= 1'b1;
            else if (ex_advance)
                ex_vld_reg <= 1'b0;
            if (ex_advance)
            begin
                out_vld_reg <= 1'b1;
                st_reg      <= st_next;
            end
            else if (out_ch.ready)
                out_vld_reg <= 1'b0;
            if (cfg_wr_en)
                reset_pc_reg <= cfg_wr_data;
        end
    end

    assign out_ch.valid          = out_vld_reg;
    assign out_ch.status         = out_res_reg.status;
    assign out_ch.fetch_pc       = out_res_reg.fetch_pc;
    assign out_ch.access         = out_res_reg.access;
    assign out_ch.access_address = out_res_reg.access_address;
    assign out_ch.access_bytes   = out_res_reg.access_bytes;
    assign out_ch.write_data     = out_res_reg.write_data;
    assign out_ch.instruction    = out_res_reg.instruction;
    assign out_ch.retired        = out_res_reg.retired;

endmodule

// ===== tb/sv/arm64_subset_instruction_step_core_test.sv =====
// ============================================================================
// arm64_subset_instruction_step_core_test
// Drives fetched instructions, data responses and restarts into the step
// core, predicts each result from an architectural model kept in the bench,
// and checks every result field in order.
// ============================================================================
module arm64_subset_instruction_step_core_test;
    import a4s_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // kind code outside the decoded set
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] data;
        logic        bus_ok;
    } step_item_t;

    logic clk;
    logic rst_n;
    logic        cfg_wr_en;
    logic [63:0] cfg_wr_data;

    a4s_in_if  in_ch ();
    a4s_out_if out_ch ();

    arm64_subset_instruction_step_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch.sink),
        .out_ch      (out_ch.source)
    );

    // architectural state mirrored by the bench
    logic [63:0] arch_x [GeneralRegCount];
    logic [63:0] arch_sp;
    logic [63:0] arch_pc;
    logic        arch_halted;
    logic [63:0] arch_retired;
    logic [1:0]  arch_pend_acc;
    logic [4:0]  arch_pend_dest;
    logic        arch_pend_wide;
    logic [31:0] arch_pend_word;
    logic [63:0] boot_pc;

    step_item_t  pending_items [$];
    a4s_result_t expected_results [$];
    int          error_count;
    bit          stim_done;
    bit          hold_sink;
    int          sink_hold_cycles;
    int          idle_cycles;
    bit          in_fire;
    bit          out_fire;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] read_x(logic [4:0] r, bit sp_ok);
        if (r != REG_ZR) return arch_x[r];
        return sp_ok ? arch_sp : 64'd0;
    endfunction

    function automatic void write_x(logic [4:0] r, logic [63:0] v, bit wide, bit sp_ok);
        if (!wide) v[63:32] = 32'd0;
        if (r != REG_ZR) arch_x[r] = v;
        else if (sp_ok) arch_sp = v;
    endfunction

    function automatic void clear_arch();
        for (int i = 0; i < GeneralRegCount; i++) arch_x[i] = 64'd0;
        arch_sp        = 64'd0;
        arch_pc        = boot_pc;
        arch_halted    = 1'b0;
        arch_retired   = 64'd0;
        arch_pend_acc  = ACC_NONE;
        arch_pend_dest = 5'd0;
        arch_pend_wide = 1'b0;
        arch_pend_word = 32'd0;
    endfunction

    // execute one fetched word against the mirrored state
    function automatic void execute_word(logic [31:0] w, ref a4s_result_t r);
        logic [63:0] next_pc;
        logic [63:0] imm;
        logic [63:0] v;
        logic [63:0] lhs;
        logic [31:0] cls;
        logic [5:0]  sh;
        bit          wide;
        bit          load;
        next_pc = arch_pc + 64'd4;
        wide = w[31];
        if (w == ENC_NOP)
        begin
            arch_pc = next_pc; arch_retired++; r.status = ST_OK; return;
        end
        if ((w & MASK_HLT) == ENC_HLT)
        begin
            arch_halted = 1'b1; arch_retired++; r.status = ST_HALTED; return;
        end
        cls = w & MASK_BR;
        if (cls == ENC_B || cls == ENC_BL)
        begin
            v = {{36{w[25]}}, w[25:0], 2'b00};
            if (cls == ENC_BL) arch_x[REG_LR] = next_pc;
            arch_pc = arch_pc + v; arch_retired++; r.status = ST_OK; return;
        end
        if ((w & MASK_RET) == ENC_RET)
        begin
            arch_pc = read_x(w[9:5], 0); arch_retired++; r.status = ST_OK; return;
        end
        cls = w & MASK_MOV;
        if (cls == ENC_MOVZ || cls == ENC_MOVK)
        begin
            if (!wide && w[22]) begin r.status = ST_UNIMPL; return; end
            sh = {w[22:21], 4'd0};
            imm = {48'd0, w[20:5]} << sh;
            v = imm;
            if (cls == ENC_MOVK) v = (read_x(w[4:0], 0) & ~(64'hFFFF << sh)) | imm;
            write_x(w[4:0], v, wide, 0);
            arch_pc = next_pc; arch_retired++; r.status = ST_OK; return;
        end
        if (cls == ENC_ADDI || cls == ENC_SUBI)
        begin
            imm = {52'd0, w[21:10]};
            if (w[22]) imm = imm << 12;
            lhs = read_x(w[9:5], 1);
            write_x(w[4:0], cls == ENC_SUBI ? lhs - imm : lhs + imm, wide, 1);
            arch_pc = next_pc; arch_retired++; r.status = ST_OK; return;
        end
        cls = w & MASK_LDST;
        if (cls == ENC_STR_X || cls == ENC_LDR_X || cls == ENC_STR_W || cls == ENC_LDR_W)
        begin
            wide = w[30];
            load = w[22];
            arch_pend_acc  = load ? ACC_READ : ACC_WRITE;
            arch_pend_dest = w[4:0];
            arch_pend_wide = wide;
            arch_pend_word = w;
            r.access = arch_pend_acc;
            r.access_bytes = wide ? 4'd8 : 4'd4;
            r.access_address = read_x(w[9:5], 1) + {52'd0, w[21:10]} * (wide ? 64'd8 : 64'd4);
            if (!load)
            begin
                v = read_x(w[4:0], 0);
                r.write_data = wide ? v : {32'd0, v[31:0]};
            end
            r.status = ST_WAIT;
            return;
        end
        r.status = ST_UNIMPL;
    endfunction

    // compute the result of one accepted item and advance the mirror
    function automatic a4s_result_t predict_step(step_item_t it);
        a4s_result_t r;
        r = '0;
        r.status = ST_ORDER;
        if (it.kind == KIND_RESTART)
        begin
            clear_arch();
            r.status = ST_OK;
        end
        else if (it.kind == KIND_INSTR)
        begin
            if (arch_halted) r.status = ST_HALTED;
            else if (arch_pend_acc != ACC_NONE) r.status = ST_ORDER;
            else if (!it.bus_ok) r.status = ST_FAULT;
            else
            begin
                r.instruction = it.data[31:0];
                execute_word(it.data[31:0], r);
            end
        end
        else if (it.kind == KIND_RESP && arch_pend_acc != ACC_NONE)
        begin
            r.instruction = arch_pend_word;
            if (!it.bus_ok) r.status = ST_FAULT;
            else
            begin
                if (arch_pend_acc == ACC_READ) write_x(arch_pend_dest, it.data, arch_pend_wide, 0);
                arch_pc = arch_pc + 64'd4;
                arch_retired++;
                r.status = ST_OK;
            end
            arch_pend_acc  = ACC_NONE;
            arch_pend_dest = 5'd0;
            arch_pend_wide = 1'b0;
            arch_pend_word = 32'd0;
        end
        r.fetch_pc = arch_pc;
        r.retired  = arch_retired;
        return r;
    endfunction

    // record which channels had a transfer at the last rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_fire  <= 1'b0;
            out_fire <= 1'b0;
        end
        else
        begin
            in_fire  <= in_ch.valid && in_ch.ready;
            out_fire <= out_ch.valid && out_ch.ready;
        end
    end

    // driver: offer queued items with a random gap between items
    int src_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid  <= 1'b0;
            in_ch.kind   <= KIND_INSTR;
            in_ch.data   <= 64'd0;
            in_ch.bus_ok <= 1'b0;
            src_gap      = 0;
        end
        else if (in_ch.valid && !in_fire)
        begin
            // hold the offered item
        end
        else if (src_gap > 0 || pending_items.size() == 0)
        begin
            in_ch.valid <= 1'b0;
            if (src_gap > 0) src_gap--;
        end
        else
        begin
            step_item_t it;
            it = pending_items.pop_front();
            in_ch.valid  <= 1'b1;
            in_ch.kind   <= it.kind;
            in_ch.data   <= it.data;
            in_ch.bus_ok <= it.bus_ok;
            src_gap      = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) src_gap = 0;
        end
    end

    // sink ready: random stalls per result, plus an optional long hold
    int snk_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            snk_gap = 0;
            sink_hold_cycles = 0;
        end
        else if (hold_sink || sink_hold_cycles > 0)
        begin
            out_ch.ready <= 1'b0;
            if (sink_hold_cycles > 0) sink_hold_cycles--;
        end
        else if (out_fire)
        begin
            snk_gap = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) snk_gap = 0;
            out_ch.ready <= (snk_gap == 0);
        end
        else if (snk_gap > 0)
        begin
            snk_gap--;
            out_ch.ready <= (snk_gap == 0);
        end
        else
            out_ch.ready <= 1'b1;
    end

    // monitor: predict on input transfer, compare on output transfer
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_ch.valid && in_ch.ready)
            begin
                step_item_t it;
                it = '{kind: in_ch.kind, data: in_ch.data, bus_ok: in_ch.bus_ok};
                expected_results.push_back(predict_step(it));
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no expectation, status %0d", out_ch.status);
                    error_count++;
                end
                else
                begin
                    a4s_result_t e;
                    e = expected_results.pop_front();
                    if (out_ch.status !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, out_ch.status);
                        error_count++;
                    end
                    if (out_ch.fetch_pc !== e.fetch_pc)
                    begin
                        $error("fetch_pc exp %h got %h", e.fetch_pc, out_ch.fetch_pc);
                        error_count++;
                    end
                    if (out_ch.access !== e.access)
                    begin
                        $error("access exp %0d got %0d", e.access, out_ch.access);
                        error_count++;
                    end
                    if (out_ch.access_address !== e.access_address)
                    begin
                        $error("access_address exp %h got %h", e.access_address,
                               out_ch.access_address);
                        error_count++;
                    end
                    if (out_ch.access_bytes !== e.access_bytes)
                    begin
                        $error("access_bytes exp %0d got %0d", e.access_bytes,
                               out_ch.access_bytes);
                        error_count++;
                    end
                    if (out_ch.write_data !== e.write_data)
                    begin
                        $error("write_data exp %h got %h", e.write_data, out_ch.write_data);
                        error_count++;
                    end
                    if (out_ch.instruction !== e.instruction)
                    begin
                        $error("instruction exp %h got %h", e.instruction, out_ch.instruction);
                        error_count++;
                    end
                    if (out_ch.retired !== e.retired)
                    begin
                        $error("retired exp %h got %h", e.retired, out_ch.retired);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog: abort when nothing transfers for too long
    always @(posedge clk)
    begin
        if (idle_cycles > 5000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void push_item(logic [1:0] k, logic [63:0] d, logic ok);
        pending_items.push_back('{kind: k, data: d, bus_ok: ok});
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random register index from 0 to 7, with 31 sometimes
    function automatic logic [4:0] rreg();
        return ($urandom_range(0, 4) == 0) ? 5'd31 : 5'($urandom_range(0, 7));
    endfunction

    // mostly well-formed instruction with random content
    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        logic [31:0] base;
        w = $urandom();
        case ($urandom_range(0, 11))
            0: return ENC_NOP;
            1: return ENC_HLT | (w & 32'h001FFFE0);
            2: return (($urandom_range(0, 1) ? ENC_BL : ENC_B)) | (w & 32'h03FFFFFF);
            3: return ENC_RET | ({27'd0, rreg()} << 5);
            4, 5:
            begin
                base = $urandom_range(0, 1) ? ENC_MOVZ : ENC_MOVK;
                return base | (w & 32'h807FFFE0) | {27'd0, rreg()};
            end
            6, 7:
            begin
                base = $urandom_range(0, 1) ? ENC_ADDI : ENC_SUBI;
                return base | (w & 32'h80FFFC00) | ({27'd0, rreg()} << 5) | {27'd0, rreg()};
            end
            8, 9, 10:
            begin
                case ($urandom_range(0, 3))
                    0: base = ENC_STR_X;
                    1: base = ENC_LDR_X;
                    2: base = ENC_STR_W;
                    default: base = ENC_LDR_W;
                endcase
                return base | (w & 32'h003FFC00) | ({27'd0, rreg()} << 5) | {27'd0, rreg()};
            end
            default: return w;
        endcase
    endfunction

    // true when the last queued instruction was a load or store
    function automatic bit arch_pend_acc_in_queue();
        logic [31:0] cls;
        if (pending_items.size() == 0) return 0;
        if (pending_items[$].kind != KIND_INSTR) return 0;
        cls = pending_items[$].data[31:0] & MASK_LDST;
        return cls == ENC_STR_X || cls == ENC_LDR_X || cls == ENC_STR_W || cls == ENC_LDR_W;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_results.size() != 0 || in_ch.valid)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_boot_pc(logic [63:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        boot_pc = v;
    endtask

    // stimulus
    initial
    begin
        logic [63:0] settings [4];
        logic [31:0] w;
        bit          ok;
        error_count = 0;
        hold_sink   = 1'b0;
        stim_done   = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 64'd0;
        boot_pc     = 64'd0;
        clear_arch();
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: each special case
        push_item(KIND_INSTR, {32'hFFFF_FFFF, ENC_NOP}, 1'b1);
        push_item(KIND_INSTR, 64'd0, 1'b0);
        push_item(KIND_INSTR, {32'd0, ENC_MOVZ | 32'h001F_FFE1}, 1'b1);
        push_item(KIND_INSTR, {32'd0, 32'hF2E0_0001 | (32'hFFFF << 5)}, 1'b1);
        push_item(KIND_INSTR, {32'd0, ENC_MOVZ | (32'd2 << 21)}, 1'b1);
        push_item(KIND_INSTR, {32'd0, ENC_ADDI | 32'h00FF_FC3F}, 1'b1);
        push_item(KIND_INSTR, {32'd0, 32'hD100_07FF}, 1'b1);
        push_item(KIND_INSTR, {32'd0, ENC_ADDI | 32'h0080_0000}, 1'b1);
        push_item(KIND_INSTR, {32'd0, ENC_STR_X | 32'h003F_FC21}, 1'b1);
        push_item(KIND_INSTR, {32'd0, ENC_NOP}, 1'b1);
        push_item(KIND_RESP, 64'd0, 1'b1);
        push_item(KIND_RESP, 64'd0, 1'b1);
        push_item(KIND_INSTR, {32'd0, ENC_LDR_W | 32'h0000_07E2}, 1'b1);
        push_item(KIND_RESP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        push_item(KIND_INSTR, {32'd0, ENC_LDR_X | 32'h0000_0003}, 1'b1);
        push_item(KIND_RESP, 64'hDEAD_BEEF_0000_0001, 1'b0);
        push_item(KIND_INSTR, {32'd0, ENC_BL | 32'h0200_0000}, 1'b1);
        push_item(KIND_INSTR, {32'd0, ENC_RET | (32'd30 << 5)}, 1'b1);
        push_item(KIND_INSTR, {32'd0, ENC_B | 32'h01FF_FFFF}, 1'b1);
        push_item(KIND_UNKNOWN, 64'd0, 1'b1);
        push_item(KIND_INSTR, {32'd0, ENC_HLT}, 1'b1);
        push_item(KIND_INSTR, {32'd0, ENC_NOP}, 1'b1);
        push_item(KIND_RESTART, rand64(), 1'b0);
        wait_drained();

        settings[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        settings[1] = 64'hFFFF_FFFF_FFFF_FFF0;
        settings[2] = rand64();
        settings[3] = 64'd0;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_boot_pc(settings[ph]);
            push_item(KIND_RESTART, 64'd0, 1'b1);
            for (int n = 0; n < 250; n++)
            begin
                // respond to a pending access most of the time
                if (arch_pend_acc_in_queue() && $urandom_range(0, 7) != 0)
                    push_item(KIND_RESP, rand64(), $urandom_range(0, 7) != 0);
                else if ($urandom_range(0, 60) == 0)
                    push_item(KIND_RESTART, rand64(), 1'($urandom()));
                else if ($urandom_range(0, 40) == 0)
                    push_item($urandom_range(0, 1) ? KIND_RESP : KIND_UNKNOWN, rand64(),
                              1'($urandom()));
                else
                begin
                    w  = rand_word();
                    ok = $urandom_range(0, 15) != 0;
                    push_item(KIND_INSTR, {$urandom(), w}, ok);
                end
            end
            if (ph == 1)
            begin
                // long sink hold while the source keeps offering
                sink_hold_cycles = 300;
            end
            wait_drained();
        end
        stim_done = 1'b1;
        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== arm64_subset_instruction_step_core.f =====
design/a4s_pkg.sv
design/a4s_if.sv
design/a4s_regfile.sv
design/a4s_exec.sv
design/arm64_subset_instruction_step_core.sv
tb/sv/arm64_subset_instruction_step_core_test.sv
